// ===== hw/rtl/nsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types, constants and character tables of the NMEA sentence filter.
// ----------------------------------------------------------------------------
package nsf_pkg;

    localparam int READING_DEPTH = 64;
    localparam int STATUS_LEN    = 4;
    localparam int ZERO_SPAN     = 8;
    localparam int HI_DEPTH      = READING_DEPTH - ZERO_SPAN;
    localparam int ADDR_W        = $clog2(READING_DEPTH);
    localparam int HI_ADDR_W     = $clog2(HI_DEPTH);
    localparam int LO_ADDR_W     = $clog2(ZERO_SPAN);
    localparam int WIDX_W        = $clog2(READING_DEPTH + 1);
    localparam int RIDX_W        = 6;
    localparam int IDX_CMP_W     = 10;

    localparam logic [7:0] CR_BYTE     = 8'h0d;
    localparam logic [7:0] DOLLAR_BYTE = 8'h24;

    typedef enum logic [2:0] {
        ACT_BYTE   = 3'd0,
        ACT_CLEAR  = 3'd1,
        ACT_LOCK   = 3'd2,
        ACT_UNLOCK = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_LOC     = 2'd1,
        EV_ANT     = 2'd2,
        EV_DROPPED = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        MODE_HEADER  = 3'd0,
        MODE_FIRST   = 3'd1,
        MODE_TAG_LOC = 3'd2,
        MODE_TAG_ANT = 3'd3,
        MODE_READING = 3'd4,
        MODE_SUFFIX  = 3'd5,
        MODE_CAPTURE = 3'd6,
        MODE_WAIT_CR = 3'd7
    } mode_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [7:0]           data;
        logic [ZERO_SPAN-1:0] zero_mask;
    } store_wr_t;

    function automatic logic [7:0] tag_char(input logic ant, input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = ant ? 8'h41 : 8'h47;
            2'd1:    c = ant ? 8'h4e : 8'h50;
            2'd2:    c = ant ? 8'h54 : 8'h52;
            default: c = ant ? 8'h53 : 8'h4d;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] suffix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h54;
            3'd1:    c = 8'h41;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h55;
            3'd4:    c = 8'h53;
            3'd5:    c = 8'h3d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [ZERO_SPAN-1:0] zero_from(input logic [WIDX_W-1:0] start);
        logic [ZERO_SPAN-1:0] m;
        for (int i = 0; i < ZERO_SPAN; i++) begin
            m[i] = (IDX_CMP_W'(i) >= IDX_CMP_W'(start));
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/nsf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_parser
// Sentence parser state machine with ready and lock flags; issues buffer
// writes and the event code for each transaction.
// ----------------------------------------------------------------------------
module nsf_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  nsf_pkg::action_t    action,
    input  logic [7:0]          rx_byte,
    output nsf_pkg::store_wr_t  wr,
    output nsf_pkg::event_t     event_code,
    output logic                ready_next,
    output logic                lock_next
);
    import nsf_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [2:0]        mpos_reg, mpos_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic              ready_reg;
    logic              lock_reg;
    logic              take;
    logic              is_cr;
    logic [1:0]        tag_pos;
    logic [2:0]        mpos_inc;
    logic [WIDX_W-1:0] widx_inc;
    logic              tag_hit;
    logic              sfx_hit;
    logic              end_loc;

    assign take     = fire && (action == ACT_BYTE) && !lock_reg;
    assign is_cr    = (rx_byte == CR_BYTE);
    assign tag_pos  = mpos_reg[1:0];
    assign mpos_inc = 3'({1'b0, tag_pos} + 3'd1);
    assign widx_inc = widx_reg + WIDX_W'(1);
    assign tag_hit  = (rx_byte == tag_char(mode_reg == MODE_TAG_ANT, tag_pos));
    assign sfx_hit  = (mpos_reg < 3'd6) && (rx_byte == suffix_char(mpos_reg));

    always_comb begin
        mode_next = mode_reg;
        mpos_next = mpos_reg;
        widx_next = widx_reg;
        if (take) begin
            unique case (mode_reg)
                MODE_HEADER: begin
                    if (rx_byte == DOLLAR_BYTE) begin
                        mode_next = MODE_FIRST;
                        mpos_next = 3'd0;
                        widx_next = '0;
                    end
                end
                MODE_FIRST: begin
                    if (rx_byte == tag_char(1'b0, 2'd0)) begin
                        mode_next = MODE_TAG_LOC;
                        mpos_next = 3'd1;
                    end else if (rx_byte == tag_char(1'b1, 2'd0)) begin
                        mode_next = MODE_TAG_ANT;
                        mpos_next = 3'd1;
                    end else begin
                        mode_next = MODE_HEADER;
                        mpos_next = 3'd0;
                    end
                end
                MODE_TAG_LOC, MODE_TAG_ANT: begin
                    if (tag_hit) begin
                        mpos_next = mpos_inc;
                        if (mpos_inc >= 3'd4) begin
                            mode_next = (mode_reg == MODE_TAG_LOC) ? MODE_READING
                                                                   : MODE_SUFFIX;
                            mpos_next = 3'd0;
                            widx_next = '0;
                        end
                    end else begin
                        mode_next = MODE_HEADER;
                        mpos_next = 3'd0;
                    end
                end
                MODE_READING: begin
                    if (widx_reg < WIDX_W'(READING_DEPTH)) begin
                        widx_next = widx_inc;
                    end
                    if (is_cr) begin
                        mode_next = MODE_HEADER;
                        mpos_next = 3'd0;
                    end
                end
                MODE_SUFFIX: begin
                    if (sfx_hit) begin
                        mpos_next = 3'(mpos_reg + 3'd1);
                        if (mpos_reg == 3'd5) begin
                            mode_next = MODE_CAPTURE;
                            mpos_next = 3'd0;
                            widx_next = '0;
                        end
                    end else begin
                        mode_next = MODE_HEADER;
                        mpos_next = 3'd0;
                    end
                end
                MODE_CAPTURE: begin
                    if (is_cr) begin
                        mode_next = MODE_HEADER;
                        mpos_next = 3'd0;
                    end else begin
                        widx_next = widx_inc;
                        if (widx_inc >= WIDX_W'(STATUS_LEN)) begin
                            mode_next = MODE_WAIT_CR;
                        end
                    end
                end
                MODE_WAIT_CR: begin
                    if (is_cr) begin
                        mode_next = MODE_HEADER;
                        mpos_next = 3'd0;
                    end
                end
                default: begin
                    mode_next = MODE_HEADER;
                end
            endcase
        end
    end

    always_comb begin
        wr         = '0;
        event_code = EV_NONE;
        end_loc    = 1'b0;
        wr.addr    = ADDR_W'(widx_reg);
        wr.data    = rx_byte;
        if (take) begin
            unique case (mode_reg)
                MODE_READING: begin
                    if (widx_reg < WIDX_W'(READING_DEPTH)) begin
                        wr.en = 1'b1;
                        if (is_cr) begin
                            event_code = EV_LOC;
                        end
                    end else begin
                        event_code = EV_DROPPED;
                    end
                    end_loc = is_cr;
                end
                MODE_CAPTURE: begin
                    if (is_cr) begin
                        wr.zero_mask = zero_from(widx_reg);
                        event_code   = EV_ANT;
                    end else begin
                        wr.en = (widx_reg < WIDX_W'(STATUS_LEN));
                        if (widx_inc >= WIDX_W'(STATUS_LEN)) begin
                            wr.zero_mask = zero_from(WIDX_W'(STATUS_LEN));
                            event_code   = EV_ANT;
                        end
                    end
                end
                default: begin
                    wr.en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        ready_next = ready_reg;
        lock_next  = lock_reg;
        if (fire) begin
            case (action)
                ACT_CLEAR:  ready_next = 1'b0;
                ACT_LOCK:   lock_next  = 1'b1;
                ACT_UNLOCK: lock_next  = 1'b0;
                default:    ready_next = ready_reg | end_loc;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_HEADER;
            mpos_reg  <= 3'd0;
            widx_reg  <= '0;
            ready_reg <= 1'b0;
            lock_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            mpos_reg  <= mpos_next;
            widx_reg  <= widx_next;
            ready_reg <= ready_next;
            lock_reg  <= lock_next;
        end
    end

`ifndef SYNTHESIS
    a_capture_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_CAPTURE |-> widx_reg < WIDX_W'(STATUS_LEN))
        else $error("capture index past status length");

    a_locked_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && lock_reg && action == ACT_BYTE |=> $stable(mode_reg) && $stable(widx_reg))
        else $error("parser advanced while buffer locked");

    a_reading_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        widx_reg <= WIDX_W'(READING_DEPTH))
        else $error("write index past depth");
`endif

endmodule

// ===== hw/rtl/nsf_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_store
// Reading buffer: low entries in flops for block zeroing, upper entries in a
// memory with per-entry valid bits; registered read port.
// ----------------------------------------------------------------------------
module nsf_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  nsf_pkg::store_wr_t            wr,
    input  logic                          rd_req,
    input  logic [nsf_pkg::RIDX_W-1:0]    rd_idx,
    output logic [7:0]                    read_data
);
    import nsf_pkg::*;

    logic [7:0]          lo_bank_reg [ZERO_SPAN];
    logic [7:0]          mem [HI_DEPTH];
    logic [HI_DEPTH-1:0] hi_valid_reg;
    logic [7:0]          mem_rd_reg;
    logic [7:0]          lo_rd_reg;
    logic                rd_act_reg;
    logic                rd_hi_reg;
    logic                rd_valid_reg;
    logic                wr_hi;
    logic                rd_hi;
    logic                rd_in_range;
    logic [ADDR_W-1:0]   raddr;
    logic [HI_ADDR_W-1:0] hi_waddr;
    logic [HI_ADDR_W-1:0] hi_raddr;

    assign wr_hi       = (wr.addr >= ADDR_W'(ZERO_SPAN));
    assign hi_waddr    = HI_ADDR_W'(wr.addr - ADDR_W'(ZERO_SPAN));
    assign rd_in_range = (IDX_CMP_W'(rd_idx) < IDX_CMP_W'(READING_DEPTH));
    assign raddr       = ADDR_W'(rd_idx);
    assign rd_hi       = (raddr >= ADDR_W'(ZERO_SPAN));
    assign hi_raddr    = HI_ADDR_W'(raddr - ADDR_W'(ZERO_SPAN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ZERO_SPAN; i++) begin
                lo_bank_reg[i] <= 8'h00;
            end
        end else begin
            for (int i = 0; i < ZERO_SPAN; i++) begin
                if (wr.zero_mask[i]) begin
                    lo_bank_reg[i] <= 8'h00;
                end
                if (wr.en && !wr_hi && wr.addr[LO_ADDR_W-1:0] == LO_ADDR_W'(i)) begin
                    lo_bank_reg[i] <= wr.data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_valid_reg <= '0;
        end else if (wr.en && wr_hi) begin
            hi_valid_reg[hi_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr_hi) begin
            mem[hi_waddr] <= wr.data;
        end
        if (fire && rd_hi) begin
            mem_rd_reg <= mem[hi_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            lo_rd_reg <= lo_bank_reg[raddr[LO_ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_act_reg   <= 1'b0;
            rd_hi_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else if (fire) begin
            rd_act_reg   <= rd_req && rd_in_range;
            rd_hi_reg    <= rd_hi;
            rd_valid_reg <= rd_hi && hi_valid_reg[hi_raddr];
        end
    end

    always_comb begin
        read_data = 8'h00;
        if (rd_act_reg) begin
            if (!rd_hi_reg) begin
                read_data = lo_rd_reg;
            end else if (rd_valid_reg) begin
                read_data = mem_rd_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_single_port: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> !(fire && rd_req))
        else $error("write and read in the same transaction");

    a_hi_written_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en && wr_hi |=> hi_valid_reg[$past(hi_waddr)])
        else $error("upper entry written but not marked valid");

    a_zero_low_only: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en && wr_hi |-> wr.zero_mask == '0)
        else $error("zeroing with an upper write");
`endif

endmodule

// ===== hw/rtl/nmea_sentence_filter_core.sv =====
`timescale 1ns / 1ps
// Path: the accepted input passes the input register, then the result register, to m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls; the parser and buffer
// write fit between both registers, and the upper buffer memory is read once per transaction.
// Reset: aresetn low clears the parser and flags, zeroes the low buffer entries and drops
// the upper valid bits, so every buffer entry reads as zero.
// ----------------------------------------------------------------------------
// nmea_sentence_filter_core
// Byte-serial NMEA sentence filter with reading buffer, stream ports.
// ----------------------------------------------------------------------------
module nmea_sentence_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], rx_byte[10:3], read_index[16:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[7:0], reading_ready[8], buffer_locked[9],
                                   // event_code[11:10]
);
    import nsf_pkg::*;

    logic              in_valid_reg;
    logic [2:0]        action_reg;
    logic [7:0]        byte_reg;
    logic [RIDX_W-1:0] idx_reg;
    logic              out_valid_reg;
    logic              ready_out_reg;
    logic              lock_out_reg;
    event_t            event_reg;
    logic              advance;
    logic              fire;
    logic              s_fire;
    action_t           action;
    store_wr_t         wr;
    event_t            event_code;
    logic              ready_next;
    logic              lock_next;
    logic [7:0]        read_data;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign action   = action_t'(action_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            action_reg <= s_tdata[2:0];
            byte_reg   <= s_tdata[10:3];
            idx_reg    <= s_tdata[16:11];
        end
    end

    nsf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .action     (action),
        .rx_byte    (byte_reg),
        .wr         (wr),
        .event_code (event_code),
        .ready_next (ready_next),
        .lock_next  (lock_next)
    );

    nsf_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .wr        (wr),
        .rd_req    (action == ACT_READ),
        .rd_idx    (idx_reg),
        .read_data (read_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            ready_out_reg <= 1'b0;
            lock_out_reg  <= 1'b0;
            event_reg     <= EV_NONE;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                ready_out_reg <= ready_next;
                lock_out_reg  <= lock_next;
                event_reg     <= event_code;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, event_reg, lock_out_reg, ready_out_reg, read_data};

`ifndef SYNTHESIS
    a_loc_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && event_reg == EV_LOC |-> ready_out_reg)
        else $error("location event without ready flag");

    a_read_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && read_data != 8'h00 |-> event_reg == EV_NONE)
        else $error("read data with a parser event");

    a_accept_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");
`endif

endmodule

// ===== tb/nmea_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_filter_checker
// Watches the input and result channels of the NMEA sentence filter. Keeps
// its own copy of the parser, flags and reading buffer, predicts one result
// per accepted input transaction and compares every result field by field.
// ----------------------------------------------------------------------------
module nmea_filter_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], rx_byte[10:3], read_index[16:11]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // read_data[7:0], reading_ready[8], buffer_locked[9],
                                   // event_code[11:10]
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          loc_seen,
    output int          ant_seen,
    output int          drop_seen
);
    import nsf_pkg::*;

    localparam int          REPORT_LIMIT = 10;
    localparam logic [31:0] LOC_TAG      = "GPRM";
    localparam logic [31:0] ANT_TAG      = "ANTS";
    localparam logic [47:0] ANT_SUFFIX   = "TATUS=";

    typedef struct packed {
        logic [7:0] data;
        logic       ready;
        logic       locked;
        event_t     ev;
    } nsf_result_t;

    mode_t       parse_mode;
    int unsigned match_pos;
    int unsigned write_pos;
    logic [7:0]  reading_buf [READING_DEPTH];
    logic        ready_flag;
    logic        lock_flag;
    nsf_result_t expected_results [$];

    function automatic void clear_tail(input int unsigned start);
        for (int unsigned i = start; i < ZERO_SPAN && i < READING_DEPTH; i++) begin
            reading_buf[i] = '0;
        end
    endfunction

    function automatic event_t parse_byte(input logic [7:0] b);
        event_t      ev;
        logic [31:0] tag;
        int unsigned p;
        ev = EV_NONE;
        case (parse_mode)
            MODE_HEADER: begin
                if (b == DOLLAR_BYTE) begin
                    parse_mode = MODE_FIRST;
                    match_pos  = 0;
                    write_pos  = 0;
                end
            end
            MODE_FIRST: begin
                if (b == LOC_TAG[31:24]) begin
                    parse_mode = MODE_TAG_LOC;
                    match_pos  = 1;
                end else if (b == ANT_TAG[31:24]) begin
                    parse_mode = MODE_TAG_ANT;
                    match_pos  = 1;
                end else begin
                    parse_mode = MODE_HEADER;
                    match_pos  = 0;
                end
            end
            MODE_TAG_LOC, MODE_TAG_ANT: begin
                tag = (parse_mode == MODE_TAG_LOC) ? LOC_TAG : ANT_TAG;
                p   = match_pos % 4;
                if (b == tag[8*(3-p) +: 8]) begin
                    match_pos = p + 1;
                    if (match_pos >= 4) begin
                        parse_mode = (parse_mode == MODE_TAG_LOC) ? MODE_READING : MODE_SUFFIX;
                        match_pos  = 0;
                        write_pos  = 0;
                    end
                end else begin
                    parse_mode = MODE_HEADER;
                    match_pos  = 0;
                end
            end
            MODE_READING: begin
                if (write_pos < READING_DEPTH) begin
                    reading_buf[write_pos] = b;
                    write_pos++;
                    if (b == CR_BYTE) ev = EV_LOC;
                end else begin
                    ev = EV_DROPPED;
                end
                if (b == CR_BYTE) begin
                    ready_flag = 1'b1;
                    parse_mode = MODE_HEADER;
                    match_pos  = 0;
                end
            end
            MODE_SUFFIX: begin
                if (match_pos < 6 && b == ANT_SUFFIX[8*(5-match_pos) +: 8]) begin
                    match_pos++;
                    if (match_pos >= 6) begin
                        parse_mode = MODE_CAPTURE;
                        match_pos  = 0;
                        write_pos  = 0;
                    end
                end else begin
                    parse_mode = MODE_HEADER;
                    match_pos  = 0;
                end
            end
            MODE_CAPTURE: begin
                if (b == CR_BYTE) begin
                    clear_tail(write_pos);
                    ev         = EV_ANT;
                    parse_mode = MODE_HEADER;
                    match_pos  = 0;
                end else begin
                    if (write_pos < STATUS_LEN && write_pos < READING_DEPTH)
                        reading_buf[write_pos] = b;
                    write_pos++;
                    if (write_pos >= STATUS_LEN) begin
                        clear_tail(STATUS_LEN);
                        ev         = EV_ANT;
                        parse_mode = MODE_WAIT_CR;
                    end
                end
            end
            MODE_WAIT_CR: begin
                if (b == CR_BYTE) begin
                    parse_mode = MODE_HEADER;
                    match_pos  = 0;
                end
            end
            default: ;
        endcase
        return ev;
    endfunction

    function automatic nsf_result_t filter_step(input logic [23:0] item);
        logic [2:0]  act;
        logic [7:0]  b;
        logic [5:0]  idx;
        nsf_result_t r;
        act    = item[2:0];
        b      = item[10:3];
        idx    = item[16:11];
        r.data = '0;
        r.ev   = EV_NONE;
        case (act)
            ACT_BYTE:   if (!lock_flag) r.ev = parse_byte(b);
            ACT_CLEAR:  ready_flag = 1'b0;
            ACT_LOCK:   lock_flag = 1'b1;
            ACT_UNLOCK: lock_flag = 1'b0;
            ACT_READ:   if (idx < READING_DEPTH) r.data = reading_buf[idx];
            default: ;
        endcase
        r.ready  = ready_flag;
        r.locked = lock_flag;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        nsf_result_t seen;
        nsf_result_t want;
        if (!aresetn) begin
            parse_mode = MODE_HEADER;
            match_pos  = 0;
            write_pos  = 0;
            ready_flag = 1'b0;
            lock_flag  = 1'b0;
            for (int i = 0; i < READING_DEPTH; i++) reading_buf[i] = '0;
            expected_results.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
            loc_seen     = 0;
            ant_seen     = 0;
            drop_seen    = 0;
        end else begin
            // results first: nothing accepted in this cycle can already be on the output
            if (m_tvalid && m_tready) begin
                seen.data   = m_tdata[7:0];
                seen.ready  = m_tdata[8];
                seen.locked = m_tdata[9];
                seen.ev     = event_t'(m_tdata[11:10]);
                results_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result %0d: data=%02h ready=%0b locked=%0b event=%0d",
                                 results_seen, seen.data, seen.ready, seen.locked, seen.ev);
                end else begin
                    want = expected_results.pop_front();
                    case (want.ev)
                        EV_LOC:     loc_seen++;
                        EV_ANT:     ant_seen++;
                        EV_DROPPED: drop_seen++;
                        default: ;
                    endcase
                    if (seen.data !== want.data || seen.ready !== want.ready ||
                        seen.locked !== want.locked || seen.ev !== want.ev) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"mismatch at result %0d: expected data=%02h ready=%0b ",
                                      "locked=%0b event=%0d, got data=%02h ready=%0b ",
                                      "locked=%0b event=%0d"},
                                     results_seen, want.data, want.ready, want.locked, want.ev,
                                     seen.data, seen.ready, seen.locked, seen.ev);
                    end
                end
            end
            if (s_tvalid && s_tready) expected_results.push_back(filter_step(s_tdata));
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression of nmea_sentence_filter_core: a short directed run, then random
// location and antenna sentences, broken headers, noise, lock phases and
// buffer reads, with random idling on both channels. Checking is done by
// nmea_filter_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import nsf_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int         ITEM_TARGET  = 1350;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         IDLE_PCT     = 11;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int   fail_count;
    int   pending;
    int   results_seen;
    int   loc_seen;
    int   ant_seen;
    int   drop_seen;
    int   cycle_count = 0;
    int   item_total  = 0;
    int   tx_idle_pct = IDLE_PCT;
    logic rx_steady   = 1'b0;
    logic lock_shadow = 1'b0;

    nmea_sentence_filter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nmea_filter_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .loc_seen     (loc_seen),
        .ant_seen     (ant_seen),
        .drop_seen    (drop_seen)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nmea_sentence_filter_core regression: fail");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_item(input logic [2:0] act, input logic [7:0] b,
                              input logic [5:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, idx, b, act};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (!(act == ACT_BYTE && lock_shadow) && act <= ACT_READ) item_total++;
        if (act == ACT_LOCK) lock_shadow = 1'b1;
        else if (act == ACT_UNLOCK) lock_shadow = 1'b0;
    endtask

    task automatic drive_byte(input logic [7:0] b);
        drive_item(ACT_BYTE, b, 6'($urandom));
    endtask

    task automatic drive_text(input string s);
        for (int i = 0; i < s.len(); i++) drive_byte(s[i]);
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(8'h20, 8'h7e)) : 8'($urandom);
        if (b == CR_BYTE) b = b ^ 8'h01;
        return b;
    endfunction

    initial begin : stimulus
        int         scenario;
        int         len;
        int         cut;
        int         stop_at;
        logic [7:0] b;
        string      hdr;
        logic       drained;
        drained = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reads after reset, spare codes, locked byte, extreme bytes
        drive_item(ACT_READ, 8'h00, 6'd0);
        drive_item(ACT_READ, 8'hff, 6'd63);
        drive_item(ACT_SPARE_LO, 8'hff, 6'd63);
        drive_item(ACT_SPARE_LO + 3'd1, 8'h00, 6'd0);
        drive_item(ACT_SPARE_HI, 8'haa, 6'd21);
        drive_item(ACT_LOCK, 8'h00, 6'd0);
        drive_byte(DOLLAR_BYTE);
        drive_item(ACT_UNLOCK, 8'h00, 6'd0);
        drive_text("$GPRM");
        drive_byte(8'hff);
        drive_byte(8'h00);
        drive_byte(CR_BYTE);
        drive_item(ACT_READ, 8'h55, 6'd0);
        drive_item(ACT_READ, 8'h55, 6'd2);
        drive_item(ACT_CLEAR, 8'h00, 6'd0);
        // second dollar is a tag mismatch, so the tag after it is ignored
        drive_text("$$");
        drive_byte("G");
        drive_text("$GX");

        while (item_total < ITEM_TARGET) begin
            tx_idle_pct = (item_total >= 900 && item_total < 1150) ? 0 : IDLE_PCT;
            rx_steady  <= (item_total >= 450 && item_total < 750);
            if (!drained && item_total >= 700) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (pending != 0);
                drained = 1'b1;
            end
            scenario = $urandom_range(0, 99);
            if (scenario < 38) begin
                len     = ($urandom_range(0, 99) < 5) ? $urandom_range(60, 72)
                                                      : $urandom_range(0, 24);
                stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
                drive_text("$GPRM");
                for (int i = 0; i <= len; i++) begin
                    if (i == stop_at) begin
                        drive_item(ACT_LOCK, 8'($urandom), 6'($urandom));
                        repeat ($urandom_range(1, 3)) drive_byte(8'($urandom));
                        drive_item(ACT_UNLOCK, 8'($urandom), 6'($urandom));
                    end
                    drive_byte((i == len) ? CR_BYTE : body_byte());
                end
                repeat ($urandom_range(1, 3))
                    drive_item(ACT_READ, 8'($urandom), 6'($urandom_range(0, (len < 63) ? len : 63)));
                if ($urandom_range(0, 2) == 0) drive_item(ACT_CLEAR, 8'($urandom), 6'($urandom));
            end else if (scenario < 60) begin
                len = $urandom_range(0, 6);
                drive_text("$ANTSTATUS=");
                for (int i = 0; i < len; i++) drive_byte(body_byte());
                if (len >= STATUS_LEN)
                    repeat ($urandom_range(0, 3))
                        drive_byte(($urandom_range(0, 3) == 0) ? DOLLAR_BYTE : body_byte());
                drive_byte(CR_BYTE);
                repeat ($urandom_range(1, 3))
                    drive_item(ACT_READ, 8'($urandom), 6'($urandom_range(0, ZERO_SPAN)));
            end else if (scenario < 72) begin
                if ($urandom_range(0, 1) == 0) hdr = "$GPRM";
                else hdr = "$ANTSTATUS=";
                cut = $urandom_range(1, hdr.len() - 1);
                for (int i = 0; i < cut; i++) drive_byte(hdr[i]);
                b = ($urandom_range(0, 3) == 0) ? DOLLAR_BYTE : 8'($urandom);
                if (b == hdr[cut]) b = b ^ 8'h01;
                drive_byte(b);
                for (int i = cut + 1; i < hdr.len(); i++) drive_byte(hdr[i]);
                drive_byte(body_byte());
                drive_byte(CR_BYTE);
            end else if (scenario < 82) begin
                repeat ($urandom_range(1, 8)) drive_byte(8'($urandom));
            end else if (scenario < 90) begin
                drive_item(ACT_LOCK, 8'($urandom), 6'($urandom));
                repeat ($urandom_range(0, 4))
                    drive_byte(($urandom_range(0, 1) == 0) ? DOLLAR_BYTE : 8'($urandom));
                drive_item(ACT_READ, 8'($urandom), 6'($urandom));
                drive_item(ACT_UNLOCK, 8'($urandom), 6'($urandom));
            end else if (scenario < 96) begin
                case ($urandom_range(0, 3))
                    0:       drive_item(ACT_CLEAR, 8'($urandom), 6'($urandom));
                    1:       drive_item(ACT_UNLOCK, 8'($urandom), 6'($urandom));
                    default: drive_item(ACT_READ, 8'($urandom), 6'($urandom));
                endcase
            end else begin
                drive_item(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                           8'($urandom), 6'($urandom));
                drive_item(ACT_READ, 8'($urandom), 6'($urandom));
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("covered %0d transactions (%0d counted items): all actions, spare codes, locking",
                 results_seen, item_total);
        $display("events checked: %0d location sentences, %0d antenna captures, %0d dropped bytes",
                 loc_seen, ant_seen, drop_seen);
        if (fail_count == 0) begin
            $display("nmea_sentence_filter_core regression: pass");
        end else begin
            $display("nmea_sentence_filter_core regression: fail");
        end
        $finish;
    end

endmodule
